[src/tevq_pkg.sv]
`timescale 1ns / 1ps

package tevq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TAG_WIDTH   = 8;

	localparam int YEAR_W   = 7;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int TIME_W   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;
	localparam int IN_TAG_W = 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int LEFT_W   = 5;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_POLL     = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_DUE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [IN_TAG_W-1:0] tag;
		logic [TIME_W-1:0]   due;
		logic [LEFT_W-1:0]   left;
		logic                last;
	} res_t;

	typedef struct packed {
		logic rd_en;
		logic entry_we;
		logic link_we;
	} mem_ctl_t;

	function automatic res_t mk_res(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
			logic [IN_TAG_W-1:0] tg, logic [TIME_W-1:0] tm, logic [LEFT_W-1:0] lf,
			logic ls);
		res_t r;
		r.status = st;
		r.slot   = sl;
		r.tag    = tg;
		r.due    = tm;
		r.left   = lf;
		r.last   = ls;
		return r;
	endfunction

endpackage

[src/tevq_req_if.sv]
`timescale 1ns / 1ps

interface tevq_req_if;
	import tevq_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [YEAR_W-1:0]   time_year;
	logic [MONTH_W-1:0]  time_month;
	logic [DAY_W-1:0]    time_day;
	logic [HOUR_W-1:0]   time_hour;
	logic [MINUTE_W-1:0] time_minute;
	logic [IN_TAG_W-1:0] task_tag;

	modport source (output valid, command, time_year, time_month, time_day, time_hour,
		time_minute, task_tag, input ready);
	modport sink (input valid, command, time_year, time_month, time_day, time_hour,
		time_minute, task_tag, output ready);

endinterface

[src/tevq_rsp_if.sv]
`timescale 1ns / 1ps

interface tevq_rsp_if;
	import tevq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_id;
	logic [IN_TAG_W-1:0] out_tag;
	logic [YEAR_W-1:0]   out_year;
	logic [MONTH_W-1:0]  out_month;
	logic [DAY_W-1:0]    out_day;
	logic [HOUR_W-1:0]   out_hour;
	logic [MINUTE_W-1:0] out_minute;
	logic [LEFT_W-1:0]   entries_left;
	logic                last;

	modport source (output valid, status, slot_id, out_tag, out_year, out_month, out_day,
		out_hour, out_minute, entries_left, last, input ready);
	modport sink (input valid, status, slot_id, out_tag, out_year, out_month, out_day,
		out_hour, out_minute, entries_left, last, output ready);

endinterface

[src/tevq_store.sv]
`timescale 1ns / 1ps

module tevq_store #(
	parameter int QUEUE_DEPTH = tevq_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_WIDTH   = tevq_pkg::DEF_TAG_WIDTH,
	parameter int IW          = 4,
	parameter int LW          = 5
) (
	input  logic                       clk,
	input  tevq_pkg::mem_ctl_t         ctl,
	input  logic [IW-1:0]              entry_addr,
	input  logic [tevq_pkg::TIME_W-1:0] entry_time,
	input  logic [TAG_WIDTH-1:0]       entry_tag,
	input  logic [IW-1:0]              link_addr,
	input  logic [LW-1:0]              link_data,
	input  logic [IW-1:0]              rd_addr,
	output logic [tevq_pkg::TIME_W-1:0] rd_time,
	output logic [TAG_WIDTH-1:0]       rd_tag,
	output logic [LW-1:0]              rd_link
);
	import tevq_pkg::*;

	logic [TIME_W-1:0]    time_mem [QUEUE_DEPTH];
	logic [TAG_WIDTH-1:0] tag_mem  [QUEUE_DEPTH];
	logic [LW-1:0]        link_mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			time_mem[entry_addr] <= entry_time;
			tag_mem[entry_addr]  <= entry_tag;
		end
		if (ctl.link_we) begin
			link_mem[link_addr] <= link_data;
		end
		if (ctl.rd_en) begin
			rd_time <= time_mem[rd_addr];
			rd_tag  <= tag_mem[rd_addr];
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

[src/tevq_ctrl.sv]
`timescale 1ns / 1ps

module tevq_ctrl #(
	parameter int QUEUE_DEPTH = tevq_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_WIDTH   = tevq_pkg::DEF_TAG_WIDTH,
	parameter int IW          = 4,
	parameter int LW          = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tevq_req_if.sink                    req,
	tevq_rsp_if.source                  rsp,
	output tevq_pkg::mem_ctl_t          ctl,
	output logic [IW-1:0]               entry_addr,
	output logic [tevq_pkg::TIME_W-1:0] entry_time,
	output logic [TAG_WIDTH-1:0]        entry_tag,
	output logic [IW-1:0]               link_addr,
	output logic [LW-1:0]               link_data,
	output logic [IW-1:0]               rd_addr,
	input  logic [tevq_pkg::TIME_W-1:0] rd_time,
	input  logic [TAG_WIDTH-1:0]        rd_tag,
	input  logic [LW-1:0]               rd_link
);
	import tevq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_HCMP  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_LNK1  = 3'd4;
	localparam logic [2:0] S_LNK2  = 3'd5;
	localparam logic [2:0] S_PCHK  = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	localparam logic [LW-1:0] NO_LINK = '0;

	function automatic logic [SLOT_W-1:0] slot4(logic [IW-1:0] idx);
		logic [IW+SLOT_W-1:0] x;
		x = {{SLOT_W{1'b0}}, idx};
		return x[SLOT_W-1:0];
	endfunction

	function automatic logic [LEFT_W-1:0] left5(logic [CW-1:0] c);
		logic [CW+LEFT_W-1:0] x;
		x = {{LEFT_W{1'b0}}, c};
		return x[LEFT_W-1:0];
	endfunction

	function automatic logic [IN_TAG_W-1:0] tag8(logic [TAG_WIDTH-1:0] t);
		logic [TAG_WIDTH+IN_TAG_W-1:0] x;
		x = {{IN_TAG_W{1'b0}}, t};
		return x[IN_TAG_W-1:0];
	endfunction

	logic [2:0]             state_q, state_d;
	logic [TIME_W-1:0]      key_q, key_d;
	logic [TAG_WIDTH-1:0]   tag_q, tag_d;
	logic [IW-1:0]          new_q, new_d;
	logic [IW-1:0]          p_q, p_d;
	logic [LW-1:0]          n_q, n_d;
	logic [LW-1:0]          head_q, head_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic [QUEUE_DEPTH-1:0] free_q, free_d;
	logic                   pend_q, pend_d;
	res_t                   stg_q, stg_d;
	res_t                   res_q, res_d;
	logic                   ov_q, ov_d;

	logic [IW-1:0]                  free_idx;
	logic                           key_lt;
	logic                           out_free;
	logic [IN_TAG_W+TAG_WIDTH-1:0]  in_tag_ext;

	always_comb begin
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	// The one comparator serves both commands: a poll entry is due when the
	// current time is not below its due time.
	assign key_lt     = key_q < rd_time;
	assign out_free   = !ov_q || rsp.ready;
	assign in_tag_ext = {{TAG_WIDTH{1'b0}}, req.task_tag};

	assign req.ready = (state_q == S_IDLE);

	assign entry_addr = new_q;
	assign entry_time = key_q;
	assign entry_tag  = tag_q;

	always_comb begin
		state_d   = state_q;
		key_d     = key_q;
		tag_d     = tag_q;
		new_d     = new_q;
		p_d       = p_q;
		n_d       = n_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		free_d    = free_q;
		pend_d    = pend_q;
		stg_d     = stg_q;
		res_d     = res_q;
		ov_d      = ov_q && !rsp.ready;
		ctl       = '0;
		link_addr = new_q;
		link_data = NO_LINK;
		rd_addr   = head_q[IW-1:0];

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					key_d = {req.time_year, req.time_month, req.time_day, req.time_hour,
						req.time_minute};
					tag_d = in_tag_ext[TAG_WIDTH-1:0];
					if (req.command == CMD_SCHEDULE) begin
						if (free_q == '0) begin
							stg_d   = mk_res(ST_FULL, '0, '0, '0, left5(cnt_q), 1'b1);
							state_d = S_EMIT;
						end else begin
							new_d           = free_idx;
							free_d[free_idx] = 1'b0;
							state_d         = S_ALLOC;
						end
					end else begin
						pend_d = 1'b0;
						if (!head_q[LW-1]) begin
							stg_d   = mk_res(ST_EMPTY, '0, '0, '0, left5(cnt_q), 1'b1);
							state_d = S_EMIT;
						end else begin
							ctl.rd_en = 1'b1;
							state_d   = S_PCHK;
						end
					end
				end
			end
			S_ALLOC: begin
				ctl.entry_we = 1'b1;
				cnt_d        = cnt_q + CW'(1);
				if (!head_q[LW-1]) begin
					ctl.link_we = 1'b1;
					head_d      = {1'b1, new_q};
					stg_d       = mk_res(ST_ACCEPTED, slot4(new_q), '0, '0,
						left5(cnt_q + CW'(1)), 1'b1);
					state_d     = S_EMIT;
				end else begin
					ctl.rd_en = 1'b1;
					state_d   = S_HCMP;
				end
			end
			S_HCMP: begin
				if (key_lt) begin
					ctl.link_we = 1'b1;
					link_data   = head_q;
					head_d      = {1'b1, new_q};
					stg_d       = mk_res(ST_ACCEPTED, slot4(new_q), '0, '0, left5(cnt_q), 1'b1);
					state_d     = S_EMIT;
				end else begin
					p_d = head_q[IW-1:0];
					n_d = rd_link;
					if (rd_link[LW-1]) begin
						ctl.rd_en = 1'b1;
						rd_addr   = rd_link[IW-1:0];
						state_d   = S_WALK;
					end else begin
						state_d = S_LNK1;
					end
				end
			end
			S_WALK: begin
				// Equal times keep walking, so a new entry lands after its equals.
				if (key_lt) begin
					state_d = S_LNK1;
				end else begin
					p_d = n_q[IW-1:0];
					n_d = rd_link;
					if (rd_link[LW-1]) begin
						ctl.rd_en = 1'b1;
						rd_addr   = rd_link[IW-1:0];
					end else begin
						state_d = S_LNK1;
					end
				end
			end
			S_LNK1: begin
				ctl.link_we = 1'b1;
				link_data   = n_q;
				state_d     = S_LNK2;
			end
			S_LNK2: begin
				ctl.link_we = 1'b1;
				link_addr   = p_q;
				link_data   = {1'b1, new_q};
				stg_d       = mk_res(ST_ACCEPTED, slot4(new_q), '0, '0, left5(cnt_q), 1'b1);
				state_d     = S_EMIT;
			end
			S_PCHK: begin
				if (!key_lt) begin
					// A held release goes out here once the next entry proves due, else from S_EMIT.
					if (!pend_q || out_free) begin
						if (pend_q) begin
							res_d = stg_q;
							ov_d  = 1'b1;
						end
						cnt_d = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
						stg_d = mk_res(ST_RELEASED, slot4(head_q[IW-1:0]), tag8(rd_tag), rd_time,
							left5(cnt_d), ~rd_link[LW-1]);
						pend_d = 1'b1;
						free_d[head_q[IW-1:0]] = 1'b1;
						head_d = rd_link;
						if (rd_link[LW-1]) begin
							ctl.rd_en = 1'b1;
							rd_addr   = rd_link[IW-1:0];
						end else begin
							state_d = S_EMIT;
						end
					end
				end else begin
					if (pend_q) begin
						stg_d.last = 1'b1;
					end else begin
						stg_d = mk_res(ST_NOT_DUE, slot4(head_q[IW-1:0]), '0, rd_time,
							left5(cnt_q), 1'b1);
					end
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					res_d   = stg_q;
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NO_LINK;
			cnt_q   <= '0;
			free_q  <= '1;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			free_q  <= free_d;
			pend_q  <= pend_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		tag_q <= tag_d;
		new_q <= new_d;
		p_q   <= p_d;
		n_q   <= n_d;
		stg_q <= stg_d;
		res_q <= res_d;
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = res_q.status;
	assign rsp.slot_id      = res_q.slot;
	assign rsp.out_tag      = res_q.tag;
	assign rsp.out_year     = res_q.due[TIME_W-1 -: YEAR_W];
	assign rsp.out_month    = res_q.due[MINUTE_W+HOUR_W+DAY_W +: MONTH_W];
	assign rsp.out_day      = res_q.due[MINUTE_W+HOUR_W +: DAY_W];
	assign rsp.out_hour     = res_q.due[MINUTE_W +: HOUR_W];
	assign rsp.out_minute   = res_q.due[MINUTE_W-1:0];
	assign rsp.entries_left = res_q.left;
	assign rsp.last         = res_q.last;

endmodule

[src/timed_event_queue_core.sv]
`timescale 1ns / 1ps
// Schedule: a full reply, an insert into an empty list, a new head, or a walk past the head
// to the insertion point, all by one shared comparator.
// Poll: an empty reply, a not-due reply, or releases at one per cycle while the output
// takes each result. A result waiting at the output adds stalls.
// One transaction at a time; input ready returns when the last result is registered.
// Reset clears sequencer, head pointer, entry count and frees every slot, not entry memories.

module timed_event_queue_core #(
	parameter int QUEUE_DEPTH = tevq_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_WIDTH   = tevq_pkg::DEF_TAG_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	tevq_req_if.sink   req,
	tevq_rsp_if.source rsp
);
	import tevq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = IW + 1;

	mem_ctl_t             ctl;
	logic [IW-1:0]        entry_addr;
	logic [TIME_W-1:0]    entry_time;
	logic [TAG_WIDTH-1:0] entry_tag;
	logic [IW-1:0]        link_addr;
	logic [LW-1:0]        link_data;
	logic [IW-1:0]        rd_addr;
	logic [TIME_W-1:0]    rd_time;
	logic [TAG_WIDTH-1:0] rd_tag;
	logic [LW-1:0]        rd_link;

	tevq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_WIDTH  (TAG_WIDTH),
		.IW         (IW),
		.LW         (LW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ctl       (ctl),
		.entry_addr(entry_addr),
		.entry_time(entry_time),
		.entry_tag (entry_tag),
		.link_addr (link_addr),
		.link_data (link_data),
		.rd_addr   (rd_addr),
		.rd_time   (rd_time),
		.rd_tag    (rd_tag),
		.rd_link   (rd_link)
	);

	tevq_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_WIDTH  (TAG_WIDTH),
		.IW         (IW),
		.LW         (LW)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.entry_addr(entry_addr),
		.entry_time(entry_time),
		.entry_tag (entry_tag),
		.link_addr (link_addr),
		.link_data (link_data),
		.rd_addr   (rd_addr),
		.rd_time   (rd_time),
		.rd_tag    (rd_tag),
		.rd_link   (rd_link)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tevq_pkg::*;

	localparam int QDEPTH       = DEF_QUEUE_DEPTH;
	localparam int RANDOM_ITEMS = 240;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 40;

	// Predicts the results of the timed queue and holds them until they arrive.
	class due_list_model;
		logic [TIME_W-1:0]   due_at [QDEPTH];
		logic [IN_TAG_W-1:0] tag_of [QDEPTH];
		int                  next_of [QDEPTH];
		bit                  in_use [QDEPTH];
		int                  head;
		int                  queued;
		res_t                pending_results [$];
		int                  errors;
		int                  checked;
		int                  n_accepted, n_full, n_released, n_not_due, n_empty;
		int                  longest_release;

		function new();
			head = -1;
			queued = 0;
			foreach (in_use[i]) in_use[i] = 1'b0;
		endfunction

		function void push_result(logic [STATUS_W-1:0] st, int slot, logic [IN_TAG_W-1:0] tg,
				logic [TIME_W-1:0] due, bit last);
			res_t r;
			r.status = st;
			r.slot   = SLOT_W'(slot);
			r.tag    = tg;
			r.due    = due;
			r.left   = LEFT_W'(queued);
			r.last   = last;
			pending_results.push_back(r);
		endfunction

		function void note_request(logic cmd, logic [TIME_W-1:0] t, logic [IN_TAG_W-1:0] tg);
			int s;
			int p;
			int released;
			if (cmd == CMD_SCHEDULE) begin
				s = -1;
				for (int i = QDEPTH - 1; i >= 0; i--)
					if (!in_use[i])
						s = i;
				if (s < 0) begin
					push_result(ST_FULL, 0, '0, '0, 1'b1);
					n_full++;
					return;
				end
				in_use[s] = 1'b1;
				due_at[s] = t;
				tag_of[s] = tg;
				// A new entry goes behind every entry due at the same time or earlier.
				if (head < 0 || t < due_at[head]) begin
					next_of[s] = head;
					head = s;
				end else begin
					p = head;
					while (next_of[p] >= 0 && !(t < due_at[next_of[p]]))
						p = next_of[p];
					next_of[s] = next_of[p];
					next_of[p] = s;
				end
				queued++;
				push_result(ST_ACCEPTED, s, '0, '0, 1'b1);
				n_accepted++;
				return;
			end
			released = 0;
			while (head >= 0 && due_at[head] <= t) begin
				s = head;
				head = next_of[s];
				in_use[s] = 1'b0;
				queued--;
				push_result(ST_RELEASED, s, tag_of[s], due_at[s],
					!(head >= 0 && due_at[head] <= t));
				released++;
			end
			n_released += released;
			if (released > longest_release)
				longest_release = released;
			if (released == 0) begin
				if (head >= 0) begin
					push_result(ST_NOT_DUE, head, '0, due_at[head], 1'b1);
					n_not_due++;
				end else begin
					push_result(ST_EMPTY, 0, '0, '0, 1'b1);
					n_empty++;
				end
			end
		endfunction

		function void check_result(res_t got);
			res_t exp;
			bit bad;
			checked++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d slot %0d tag %h due %h left %0d last %0d",
						got.status, got.slot, got.tag, got.due, got.left, got.last);
				return;
			end
			exp = pending_results.pop_front();
			bad = got.status !== exp.status || got.slot !== exp.slot || got.tag !== exp.tag ||
				got.due !== exp.due || got.left !== exp.left || got.last !== exp.last;
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("result %0d mismatch at %0t", checked, $realtime);
					$display("  expected status %0d slot %0d tag %h due %h left %0d last %0d",
						exp.status, exp.slot, exp.tag, exp.due, exp.left, exp.last);
					$display("  actual   status %0d slot %0d tag %h due %h left %0d last %0d",
						got.status, got.slot, got.tag, got.due, got.left, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct = 13;
	int   rcv_idle_pct = 67;
	int   sent = 0;
	int   quiet = 0;

	due_list_model sb = new();

	tevq_req_if req();
	tevq_rsp_if rsp();

	timed_event_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] pack_time(int y, int mo, int d, int h, int mi);
		return {YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h), MINUTE_W'(mi)};
	endfunction

	// Clustered times so that equal due times and partial releases are common.
	function automatic logic [TIME_W-1:0] near_time();
		return pack_time($urandom_range(21, 20), $urandom_range(6, 5), $urandom_range(15, 14),
			$urandom_range(9, 8), 15 * $urandom_range(3, 0));
	endfunction

	task automatic send_request(input logic cmd, input logic [TIME_W-1:0] t,
			input logic [IN_TAG_W-1:0] tg);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		{req.time_year, req.time_month, req.time_day, req.time_hour, req.time_minute} <= t;
		req.task_tag <= tg;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		sb.note_request(cmd, t, tg);
		sent++;
	endtask

	task automatic hold_until_drained();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_results.size() != 0);
	endtask

	// Result side: random back-pressure and checking of every accepted transaction.
	initial begin
		res_t got;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.status = rsp.status;
				got.slot   = rsp.slot_id;
				got.tag    = rsp.out_tag;
				got.due    = {rsp.out_year, rsp.out_month, rsp.out_day, rsp.out_hour,
					rsp.out_minute};
				got.left   = rsp.entries_left;
				got.last   = rsp.last;
				sb.check_result(got);
			end
			rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, sb.pending_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int target;
		int pick;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.command <= CMD_SCHEDULE;
		{req.time_year, req.time_month, req.time_day, req.time_hour, req.time_minute} <= '0;
		req.task_tag <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty poll, a full pool with extreme and equal times, the full
		// case, a partial release, a poll before the head is due, a flush.
		send_request(CMD_POLL, '0, '0);
		send_request(CMD_SCHEDULE, '1, 8'hFF);
		send_request(CMD_SCHEDULE, '0, 8'h00);
		for (int i = 0; i < 10; i++)
			send_request(CMD_SCHEDULE, pack_time(24, 6, 15, 12, 28 + i % 4), IN_TAG_W'(8'h10 + i));
		send_request(CMD_SCHEDULE, pack_time(99, 12, 31, 23, 59), 8'h80);
		send_request(CMD_SCHEDULE, pack_time(0, 1, 1, 0, 0), 8'h01);
		send_request(CMD_SCHEDULE, pack_time(24, 6, 15, 12, 30), 8'h55);
		send_request(CMD_SCHEDULE, pack_time(1, 1, 1, 1, 1), 8'h7E);
		send_request(CMD_SCHEDULE, pack_time(24, 6, 15, 12, 29), 8'hAA);
		send_request(CMD_POLL, pack_time(24, 6, 15, 12, 30), 8'hC3);
		send_request(CMD_POLL, pack_time(24, 6, 15, 12, 0), 8'h3C);
		send_request(CMD_POLL, '1, '1);
		send_request(CMD_POLL, pack_time(99, 12, 31, 23, 59), '0);

		for (int phase = 0; phase < 3; phase++) begin
			hold_until_drained();
			case (phase)
				0: begin
					send_idle_pct = 13;
					rcv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					rcv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			target = sent + RANDOM_ITEMS / 3;
			while (sent < target) begin
				if ($urandom_range(99) < 3)
					hold_until_drained();
				pick = $urandom_range(99);
				if (pick < 5) begin
					send_request(CMD_POLL, '1, IN_TAG_W'($urandom()));
				end else if (pick < 9) begin
					// Fill the pool, then one more schedule that must be refused.
					while (sb.queued < QDEPTH)
						send_request(CMD_SCHEDULE, near_time(), IN_TAG_W'($urandom()));
					send_request(CMD_SCHEDULE, near_time(), IN_TAG_W'($urandom()));
				end else if (pick < 17) begin
					send_request(1'($urandom()), TIME_W'($urandom()), IN_TAG_W'($urandom()));
				end else begin
					send_request(($urandom_range(99) < 55) ? CMD_SCHEDULE : CMD_POLL,
						near_time(), IN_TAG_W'($urandom()));
				end
			end
		end

		hold_until_drained();
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests sent: %0d schedules taken, %0d refused as full, %0d polls empty",
			sent, sb.n_accepted, sb.n_full, sb.n_empty);
		$display("%0d entries released (up to %0d per poll), %0d not-due replies, %0d errors",
			sb.n_released, sb.longest_release, sb.n_not_due, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
